@@ rtl/core/iltt_pkg.sv @@
// shared types and constants for the idle timeout lru tracker
`timescale 1ns / 1ps

package iltt_pkg;

	typedef enum logic [1:0] {
		OP_TOUCH  = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHECK  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// register index taken from paddr[2]
	localparam logic ADDR_IDLE_LIMIT = 1'b0;
	localparam logic [31:0] IDLE_LIMIT_RST = 32'd60;

	localparam int KEY_W = 6;
	localparam int OUT_TIME_W = 32;
	localparam int TOTAL_W = 7;
	// a 6-bit key reaches at most this many slots
	localparam int MAX_SLOTS = 64;

	typedef struct packed {
		logic accept;       // take key and stamp, start table reads
		logic check;        // accepted request is a timeout walk
		logic unlink;       // take the slot out of the recency list
		logic append;       // link the slot in at the tail
		logic finish;       // close a touch: store time, end link, report
		logic emit_single;  // report a remove, query or ignored touch
		logic emit_time;    // report carries the stored time
		logic clear_slot;   // drop the slot
		logic set_slot;     // claim the slot
		logic walk;         // examine one list entry
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic present;
		logic walk_done;
	} stat_t;

endpackage

@@ rtl/core/iltt_ctrl.sv @@
// request sequencer for the idle timeout lru tracker
`timescale 1ns / 1ps

module iltt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        op,
	input  iltt_pkg::stat_t   stat,
	output iltt_pkg::cmd_t    cmd,
	output logic              busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_APPEND,
		ST_FINISH,
		ST_WALK
	} state_t;

	state_t          state_q;
	iltt_pkg::op_t   op_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				cmd.check  = start && (op == iltt_pkg::OP_CHECK);
			end
			ST_DECODE: begin
				unique case (op_q)
					iltt_pkg::OP_TOUCH: begin
						if (!stat.in_range) begin
							cmd.emit_single = 1'b1;
						end else if (stat.present) begin
							cmd.unlink = 1'b1;
						end else begin
							cmd.set_slot = 1'b1;
							cmd.append   = 1'b1;
						end
					end
					iltt_pkg::OP_REMOVE: begin
						cmd.emit_single = 1'b1;
						if (stat.present) begin
							cmd.unlink     = 1'b1;
							cmd.clear_slot = 1'b1;
						end
					end
					iltt_pkg::OP_QUERY: begin
						cmd.emit_single = 1'b1;
						cmd.emit_time   = 1'b1;
					end
					iltt_pkg::OP_CHECK: begin
						// walks go straight to ST_WALK
						cmd.emit_single = 1'b0;
					end
				endcase
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= iltt_pkg::OP_TOUCH;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= iltt_pkg::op_t'(op);
						if (op == iltt_pkg::OP_CHECK) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DECODE;
						end
					end
				end
				ST_DECODE: begin
					if ((op_q == iltt_pkg::OP_TOUCH) && stat.in_range) begin
						state_q <= stat.present ? ST_APPEND : ST_FINISH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_APPEND: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (stat.walk_done) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/core/iltt_datapath.sv @@
// slot table, recency links and result registers of the idle timeout lru tracker
`timescale 1ns / 1ps

module iltt_datapath #(
	parameter int SLOTS     = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iltt_pkg::cmd_t                    cmd,
	input  logic [iltt_pkg::KEY_W-1:0]        entry_key,
	input  logic [31:0]                       stamp,
	input  logic [31:0]                       idle_limit,
	output iltt_pkg::stat_t                   stat,
	output logic                              result_valid,
	output logic [iltt_pkg::KEY_W-1:0]        out_key,
	output logic [iltt_pkg::OUT_TIME_W-1:0]   out_time,
	output logic                              found,
	output logic                              last_of_run,
	output logic [iltt_pkg::TOTAL_W-1:0]      entry_total
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	// link stores and stored times
	logic [TIME_BITS-1:0] arrive_mem [SLOTS];
	logic [LW-1:0]        prev_mem   [SLOTS];
	logic [LW-1:0]        next_mem   [SLOTS];

	logic [TIME_BITS-1:0] arrive_rd_q;
	logic [LW-1:0]        prev_rd_q;
	logic [LW-1:0]        next_rd_q;

	logic [iltt_pkg::KEY_W-1:0] key_q;
	logic [TIME_BITS-1:0]       stamp_q;
	logic [SLOTS-1:0]           valid_q;
	logic [LW-1:0]              head_q;
	logic [LW-1:0]              tail_q;
	logic [LW-1:0]              count_q;
	logic [LW-1:0]              cur_q;
	logic                       hit_q;
	logic                       pend_q;
	logic [IW-1:0]              pend_key_q;
	logic [TIME_BITS-1:0]       pend_time_q;

	logic [IW-1:0]        rd_addr;
	logic [IW-1:0]        k;
	logic                 in_range;
	logic                 present;
	logic                 p_nil;
	logic                 n_nil;
	logic                 tail_nil;
	logic                 cur_nil;
	logic [TIME_BITS-1:0] age;
	logic [TIME_BITS-1:0] limit;
	logic                 expired;
	logic [LW-1:0]        count_nx;

	logic                 next_we;
	logic [IW-1:0]        next_waddr;
	logic [LW-1:0]        next_wdata;
	logic                 prev_we;
	logic [IW-1:0]        prev_waddr;
	logic [LW-1:0]        prev_wdata;

	assign k        = key_q[IW-1:0];
	assign in_range = (32'(key_q) < 32'(SLOTS));
	assign present  = in_range && valid_q[k];
	assign p_nil    = (prev_rd_q == NIL);
	assign n_nil    = (next_rd_q == NIL);
	assign tail_nil = (tail_q == NIL);
	assign cur_nil  = (cur_q == NIL);
	assign age      = stamp_q - arrive_rd_q;
	assign limit    = TIME_BITS'(idle_limit);
	assign expired  = !cur_nil && (age >= limit);
	assign count_nx = count_q + LW'(cmd.set_slot) - LW'(cmd.clear_slot);

	assign stat.in_range  = in_range;
	assign stat.present   = present;
	assign stat.walk_done = !expired;

	// reads follow the list during a walk, start at the head on a check, else the requested key
	always_comb begin
		if (cmd.walk) begin
			rd_addr = next_rd_q[IW-1:0];
		end else if (cmd.check) begin
			rd_addr = head_q[IW-1:0];
		end else begin
			rd_addr = entry_key[IW-1:0];
		end
	end

	always_comb begin
		next_we    = 1'b0;
		next_waddr = k;
		next_wdata = NIL;
		if (cmd.unlink) begin
			next_we    = !p_nil;
			next_waddr = prev_rd_q[IW-1:0];
			next_wdata = next_rd_q;
		end else if (cmd.append) begin
			next_we    = !tail_nil;
			next_waddr = tail_q[IW-1:0];
			next_wdata = LW'(k);
		end else if (cmd.finish) begin
			next_we    = 1'b1;
		end
	end

	always_comb begin
		prev_we    = 1'b0;
		prev_waddr = k;
		prev_wdata = tail_q;
		if (cmd.unlink) begin
			prev_we    = !n_nil;
			prev_waddr = next_rd_q[IW-1:0];
			prev_wdata = prev_rd_q;
		end else if (cmd.append) begin
			prev_we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		if (cmd.finish) begin
			arrive_mem[k] <= stamp_q;
		end
		arrive_rd_q <= arrive_mem[rd_addr];
		prev_rd_q   <= prev_mem[rd_addr];
		next_rd_q   <= next_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			head_q       <= NIL;
			tail_q       <= NIL;
			count_q      <= '0;
			pend_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.set_slot) begin
				valid_q[k] <= 1'b1;
			end
			if (cmd.clear_slot) begin
				valid_q[k] <= 1'b0;
			end
			count_q <= count_nx;

			if (cmd.unlink) begin
				if (p_nil) begin
					head_q <= next_rd_q;
				end
				if (n_nil) begin
					tail_q <= prev_rd_q;
				end
			end else if (cmd.append) begin
				if (tail_nil) begin
					head_q <= LW'(k);
				end
				tail_q <= LW'(k);
			end

			// an expired entry waits in the pend registers so its last flag is known
			if (cmd.walk) begin
				pend_q <= expired;
			end

			result_valid <= cmd.emit_single || cmd.finish || (cmd.walk && pend_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q   <= entry_key;
			stamp_q <= TIME_BITS'(stamp);
		end
		if (cmd.check) begin
			cur_q <= head_q;
		end else if (cmd.walk) begin
			cur_q <= next_rd_q;
		end
		if (cmd.unlink) begin
			hit_q <= 1'b1;
		end else if (cmd.set_slot) begin
			hit_q <= 1'b0;
		end
		if (cmd.walk) begin
			pend_key_q  <= cur_q[IW-1:0];
			pend_time_q <= arrive_rd_q;
		end

		entry_total <= iltt_pkg::TOTAL_W'(count_nx);
		if (cmd.walk) begin
			out_key     <= iltt_pkg::KEY_W'(pend_key_q);
			out_time    <= iltt_pkg::OUT_TIME_W'(pend_time_q);
			found       <= 1'b1;
			last_of_run <= !expired;
		end else if (cmd.finish) begin
			out_key     <= key_q;
			out_time    <= '0;
			found       <= hit_q;
			last_of_run <= 1'b1;
		end else begin
			out_key     <= key_q;
			out_time    <= (cmd.emit_time && present) ?
				iltt_pkg::OUT_TIME_W'(arrive_rd_q) : '0;
			found       <= present;
			last_of_run <= 1'b1;
		end
	end

endmodule

@@ rtl/core/idle_timeout_lru_tracker.sv @@
// idle timeout lru tracker: busy spans decode on remove, query and ignored touch, decode and
// finish on touch of a new key, decode, append and finish on touch of a present key (link
// rewrites, one write port per link store); the result strobe rises at the edge where busy
// drops. check walks from the head one entry per cycle up to a fresh entry or the list end;
// results follow one per cycle, none when nothing expired.
// reset clears all slots (valid flops), empties the list and sets idle_limit to 60.
`timescale 1ns / 1ps

module idle_timeout_lru_tracker #(
	parameter int NUM_KEYS  = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        op,
	input  logic [iltt_pkg::KEY_W-1:0]        entry_key,
	input  logic [31:0]                       stamp,
	output logic                              result_valid,
	output logic [iltt_pkg::KEY_W-1:0]        out_key,
	output logic [iltt_pkg::OUT_TIME_W-1:0]   out_time,
	output logic                              found,
	output logic                              last_of_run,
	output logic [iltt_pkg::TOTAL_W-1:0]      entry_total,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	// keys above the key width never arrive, so the table stops there
	localparam int SLOTS = (NUM_KEYS < iltt_pkg::MAX_SLOTS) ? NUM_KEYS : iltt_pkg::MAX_SLOTS;

	iltt_pkg::cmd_t  cmd;
	iltt_pkg::stat_t stat;
	logic [31:0]     idle_limit_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == iltt_pkg::ADDR_IDLE_LIMIT) ? idle_limit_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= iltt_pkg::IDLE_LIMIT_RST;
		end else if (psel && penable && pwrite && pready &&
				(paddr[2] == iltt_pkg::ADDR_IDLE_LIMIT)) begin
			idle_limit_q <= pwdata;
		end
	end

	iltt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	iltt_datapath #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.entry_key    (entry_key),
		.stamp        (stamp),
		.idle_limit   (idle_limit_q),
		.stat         (stat),
		.result_valid (result_valid),
		.out_key      (out_key),
		.out_time     (out_time),
		.found        (found),
		.last_of_run  (last_of_run),
		.entry_total  (entry_total)
	);

endmodule

@@ test/tb_idle_timeout_lru_tracker.sv @@
// self-checking testbench for the idle timeout lru tracker: directed and random requests
`timescale 1ns / 1ps

module tb_idle_timeout_lru_tracker;

	localparam logic [6:0] NIL_LINK = 7'd64;
	localparam int STALL_LIMIT = 1000;

	typedef struct {
		iltt_pkg::op_t              op;
		logic [iltt_pkg::KEY_W-1:0] key;
		logic [31:0]                stamp;
	} request_t;

	typedef struct {
		logic [iltt_pkg::KEY_W-1:0]   key;
		logic [31:0]                  arrival;
		logic                         found;
		logic                         last;
		logic [iltt_pkg::TOTAL_W-1:0] total;
	} tracker_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	logic [1:0]                      op = iltt_pkg::OP_TOUCH;
	logic [iltt_pkg::KEY_W-1:0]      entry_key = '0;
	logic [31:0]                     stamp = '0;
	logic                            result_valid;
	logic [iltt_pkg::KEY_W-1:0]      out_key;
	logic [iltt_pkg::OUT_TIME_W-1:0] out_time;
	logic                            found;
	logic                            last_of_run;
	logic [iltt_pkg::TOTAL_W-1:0]    entry_total;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [2:0]                      paddr = '0;
	logic [31:0]                     pwdata = '0;
	logic [31:0]                     prdata;
	logic                            pready;

	idle_timeout_lru_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .entry_key(entry_key), .stamp(stamp),
		.result_valid(result_valid), .out_key(out_key), .out_time(out_time),
		.found(found), .last_of_run(last_of_run), .entry_total(entry_total),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the tracker table
	logic        slot_live [iltt_pkg::MAX_SLOTS] = '{default: 1'b0};
	logic [31:0] slot_time [iltt_pkg::MAX_SLOTS];
	logic [6:0]  slot_prev [iltt_pkg::MAX_SLOTS];
	logic [6:0]  slot_next [iltt_pkg::MAX_SLOTS];
	logic [6:0]  lru_head = NIL_LINK;
	logic [6:0]  lru_tail = NIL_LINK;
	logic [6:0]  live_count = '0;
	logic [31:0] limit_model = iltt_pkg::IDLE_LIMIT_RST;

	request_t        request_queue [$];
	tracker_result_t expected_results [$];
	request_t        in_flight;
	int              gap_left = 0;
	logic            no_idle = 1'b0;
	logic [31:0]     clock_now = '0;
	int              stall_cycles = 0;
	int              mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic void queue_request(input request_t rq);
		request_queue.insert(request_queue.size(), rq);
	endfunction

	function automatic void queue_result(input tracker_result_t res);
		expected_results.insert(expected_results.size(), res);
	endfunction

	function automatic void lru_unlink(input logic [5:0] k);
		logic [6:0] p;
		logic [6:0] n;
		p = slot_prev[k];
		n = slot_next[k];
		if (p != NIL_LINK) slot_next[p[5:0]] = n; else lru_head = n;
		if (n != NIL_LINK) slot_prev[n[5:0]] = p; else lru_tail = p;
	endfunction

	function automatic void lru_append(input logic [5:0] k);
		slot_prev[k] = lru_tail;
		slot_next[k] = NIL_LINK;
		if (lru_tail != NIL_LINK) slot_next[lru_tail[5:0]] = {1'b0, k};
		else lru_head = {1'b0, k};
		lru_tail = {1'b0, k};
	endfunction

	// apply one request to the shadow table and queue what the tracker must report
	task automatic predict_request(input request_t rq);
		tracker_result_t res;
		logic            was_live;
		logic [5:0]      k;
		logic [6:0]      cur;
		logic [31:0]     age;
		logic [5:0]      hit_key [iltt_pkg::MAX_SLOTS];
		int              n;
		k = rq.key;
		was_live = slot_live[k];
		res = '{key: k, arrival: '0, found: was_live, last: 1'b1, total: '0};
		case (rq.op)
			iltt_pkg::OP_TOUCH: begin
				if (was_live) lru_unlink(k);
				else begin
					slot_live[k] = 1'b1;
					live_count++;
				end
				lru_append(k);
				slot_time[k] = rq.stamp;
			end
			iltt_pkg::OP_REMOVE: begin
				if (was_live) begin
					lru_unlink(k);
					slot_live[k] = 1'b0;
					live_count--;
				end
			end
			iltt_pkg::OP_QUERY: begin
				if (was_live) res.arrival = slot_time[k];
			end
			default: ;
		endcase
		if (rq.op != iltt_pkg::OP_CHECK) begin
			res.total = live_count;
			queue_result(res);
		end else begin
			// walk from the oldest entry, stop at the first one still fresh
			n = 0;
			cur = lru_head;
			while (cur != NIL_LINK && n < iltt_pkg::MAX_SLOTS) begin
				age = rq.stamp - slot_time[cur[5:0]];
				if (age < limit_model) break;
				hit_key[n] = cur[5:0];
				n++;
				cur = slot_next[cur[5:0]];
			end
			for (int i = 0; i < n; i++) begin
				res = '{key: hit_key[i], arrival: slot_time[hit_key[i]], found: 1'b1,
					last: (i == n - 1), total: live_count};
				queue_result(res);
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_request(input iltt_pkg::op_t o, input int k,
			input logic [31:0] s);
		request_t rq;
		rq.op = o;
		rq.key = 6'(k);
		rq.stamp = s;
		queue_request(rq);
	endfunction

	// mostly touches at a steadily advancing clock and checks near the limit boundary
	function automatic request_t random_request();
		request_t    rq;
		int          r;
		logic [31:0] off;
		r = $urandom_range(0, 99);
		rq.key = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 11)) :
			6'($urandom_range(0, 63));
		rq.stamp = $urandom;
		if (r < 42) begin
			rq.op = iltt_pkg::OP_TOUCH;
			clock_now += $urandom_range(0, 6);
			rq.stamp = clock_now;
		end else if (r < 56) begin
			rq.op = iltt_pkg::OP_REMOVE;
		end else if (r < 68) begin
			rq.op = iltt_pkg::OP_QUERY;
		end else if (r < 90) begin
			rq.op = iltt_pkg::OP_CHECK;
			off = $urandom_range(0, 40) - 20;
			if ($urandom_range(0, 2) == 0) rq.stamp = clock_now + $urandom_range(0, 50);
			else rq.stamp = clock_now + limit_model + off;
		end else begin
			// noise: any op with a random stamp
			rq.op = iltt_pkg::op_t'($urandom_range(0, 3));
		end
		return rq;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) predict_request(in_flight);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (request_queue.size() != 0) begin
					in_flight = request_queue.pop_front();
					start <= 1'b1;
					op <= in_flight.op;
					entry_key <= in_flight.key;
					stamp <= in_flight.stamp;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		tracker_result_t want;
		if (arst_n) begin
			if ((start && !busy) || result_valid) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result key %0h", out_key));
				end else begin
					want = expected_results.pop_front();
					compare_field("out_key", out_key, want.key);
					compare_field("out_time", out_time, want.arrival);
					compare_field("found", found, want.found);
					compare_field("last_of_run", last_of_run, want.last);
					compare_field("entry_total", entry_total, want.total);
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic write_idle_limit(input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {iltt_pkg::ADDR_IDLE_LIMIT, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		limit_model = value;
		// read back through a second transfer
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field("idle_limit readback", prdata, limit_model);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		// a check with nothing expired reports nothing but still keeps the block busy
		do @(negedge clk);
		while (request_queue.size() != 0 || start || busy || expected_results.size() != 0);
	endtask

	initial begin
		int          order [iltt_pkg::MAX_SLOTS];
		int          j;
		int          swap;
		logic [31:0] lim;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, then head, middle and tail unlinks, wrapped ages
		push_request(iltt_pkg::OP_QUERY, 0, 32'h0);
		push_request(iltt_pkg::OP_REMOVE, 63, 32'h0);
		push_request(iltt_pkg::OP_CHECK, 0, 32'hFFFF_FFFF);
		push_request(iltt_pkg::OP_TOUCH, 0, 32'h0);
		push_request(iltt_pkg::OP_TOUCH, 63, 32'hFFFF_FFFF);
		push_request(iltt_pkg::OP_TOUCH, 0, 32'h0);
		push_request(iltt_pkg::OP_QUERY, 0, 32'h0);
		push_request(iltt_pkg::OP_QUERY, 63, 32'h0);
		push_request(iltt_pkg::OP_CHECK, 0, 32'd10);
		push_request(iltt_pkg::OP_CHECK, 0, 32'd59);
		push_request(iltt_pkg::OP_CHECK, 0, 32'd60);
		push_request(iltt_pkg::OP_TOUCH, 42, 32'h5555_5555);
		push_request(iltt_pkg::OP_TOUCH, 21, 32'hAAAA_AAAA);
		push_request(iltt_pkg::OP_TOUCH, 63, 32'h0000_0100);
		push_request(iltt_pkg::OP_REMOVE, 42, 32'h0);
		push_request(iltt_pkg::OP_REMOVE, 0, 32'h0);
		push_request(iltt_pkg::OP_QUERY, 42, 32'h0);
		push_request(iltt_pkg::OP_REMOVE, 42, 32'h0);
		push_request(iltt_pkg::OP_CHECK, 0, 32'hAAAA_AAE6);
		push_request(iltt_pkg::OP_REMOVE, 63, 32'h0);
		push_request(iltt_pkg::OP_TOUCH, 21, 32'd7);
		push_request(iltt_pkg::OP_REMOVE, 21, 32'h0);
		push_request(iltt_pkg::OP_CHECK, 0, 32'h0);
		wait_idle();

		// largest limit: only the full-wrap age expires
		write_idle_limit(32'hFFFF_FFFF);
		push_request(iltt_pkg::OP_TOUCH, 1, 32'd1);
		push_request(iltt_pkg::OP_CHECK, 0, 32'd0);
		push_request(iltt_pkg::OP_CHECK, 0, 32'd5);
		push_request(iltt_pkg::OP_REMOVE, 1, 32'h0);
		wait_idle();

		// zero limit with a full table: every check reports all entries
		write_idle_limit(32'h0);
		no_idle = 1'b1;
		for (int i = 0; i < iltt_pkg::MAX_SLOTS; i++) order[i] = i;
		for (int i = iltt_pkg::MAX_SLOTS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		clock_now = $urandom;
		for (int i = 0; i < iltt_pkg::MAX_SLOTS; i++) begin
			clock_now += $urandom_range(0, 3);
			push_request(iltt_pkg::OP_TOUCH, order[i], clock_now);
		end
		push_request(iltt_pkg::OP_CHECK, 0, clock_now);
		repeat (20) queue_request(random_request());
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: lim = 32'($urandom_range(1, 300));
				1: lim = $urandom;
				2: lim = iltt_pkg::IDLE_LIMIT_RST;
				3: lim = 32'hFFFF_FFFF;
				default: lim = 32'($urandom_range(1, 20));
			endcase
			write_idle_limit(lim);
			// one phase runs the clock across the wrap
			clock_now = (ph == 2) ? 32'hFFFF_FF00 : $urandom;
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (60) queue_request(random_request());
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
